// ===== hdl/uft_pkg.sv =====
// shared types and constants for the url field tokenizer
package uft_pkg;

    localparam int TOKEN_MAX_DEFAULT = 16;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_QUERY  = 8'h3F;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_EQUALS = 8'h3D;

    typedef enum logic [2:0] {
        K_DOMAIN = 3'd0,
        K_METHOD = 3'd1,
        K_KEY    = 3'd2,
        K_VALUE  = 3'd3,
        K_FEND   = 3'd4,
        K_LEND   = 3'd5
    } kind_t;

    // ordered list of result groups that one request produces
    typedef struct packed {
        logic  pre1_v;
        kind_t pre1_kind;
        logic  pre2_v;
        logic  flush1_v;
        kind_t flush1_kind;
        logic  flush2_v;
        logic  post1_v;
        logic  post2_v;
        logic  lend_v;
    } plan_t;

endpackage

// ===== hdl/uft_ram.sv =====
// generic single-write, single-read ram with registered read data
module uft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/url_field_tokenizer_unit.sv =====
// top level of the url field tokenizer: request decode, result sequencer, token ram
//
// usage
//   s_ channel: one url byte per request, s_tlast marks the last byte of a line
//   m_ channel: tagged field bytes and marker items, m_tlast marks the final
//   result caused by one input request
//   domain bytes and value bytes pass straight through; method text and keys
//   collect in a small token ram and are read back when the field closes
// sequencing
//   a request is taken only while the sequencer is idle; then each direct result
//   (domain, value, field end, line end) goes straight to the output register and
//   each byte read back from the token ram takes a ram read, then an output load
//   a request that yields nothing leaves the sequencer idle; a pair without '='
//   at the line end replays the buffer twice
// reset
//   aresetn low clears the parse state, the token length and the output valid;
//   the ram contents are not cleared, only entries below the length are read
// backpressure
//   results sit in a single output register; while it is full and m_tready is
//   low the sequencer holds, and no new request is taken until its last result is loaded
module url_field_tokenizer_unit import uft_pkg::*; #(
    parameter int TOKEN_MAX = TOKEN_MAX_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic       s_tlast,   // line_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [3:0] m_tuser,   // [2:0] kind, [3] overflow
    output logic       m_tlast    // last_of_run
);

    localparam int AW = $clog2(TOKEN_MAX);
    localparam int LW = $clog2(TOKEN_MAX + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMIT,
        S_FDATA
    } state_t;

    // result groups in emission order
    typedef enum logic [2:0] {
        P_PRE1   = 3'd0,
        P_PRE2   = 3'd1,
        P_FLUSH1 = 3'd2,
        P_FLUSH2 = 3'd3,
        P_POST1  = 3'd4,
        P_POST2  = 3'd5,
        P_LEND   = 3'd6,
        P_DONE   = 3'd7
    } pos_t;

    // first enabled group at or after a position
    function automatic pos_t first_from(logic [2:0] from, plan_t pl);
        logic [6:0] en;
        pos_t       r;
        en = {pl.lend_v, pl.post2_v, pl.post1_v, pl.flush2_v,
              pl.flush1_v, pl.pre2_v, pl.pre1_v};
        r = P_DONE;
        for (int i = 6; i >= 0; i--) begin
            if (en[i] && (3'(i) >= from)) begin
                r = pos_t'(3'(i));
            end
        end
        return r;
    endfunction

    // parse state
    logic [1:0]    slash_reg;
    logic          in_query_reg;
    logic          saw_eq_reg;
    logic          value_started_reg;
    logic [LW-1:0] len_reg;
    logic          dropped_reg;

    // per-request sequencer state
    state_t        state_reg;
    pos_t          pos_reg;
    plan_t         plan_reg;
    logic [7:0]    char_reg;
    logic [LW-1:0] flen_reg;
    logic          fovf_reg;
    logic [LW-1:0] idx_reg;

    // output register
    logic          m_tvalid_reg;
    logic [7:0]    m_byte_reg;
    kind_t         m_kind_reg;
    logic          m_ovf_reg;
    logic          m_tlast_reg;

    // decode of the incoming request
    logic [1:0]    slash_next;
    logic          in_query_next;
    logic          saw_eq_next;
    logic          value_started_next;
    logic [LW-1:0] len_next;
    logic          dropped_next;
    plan_t         plan_next;
    logic [LW-1:0] flen_next;
    logic          fovf_next;
    logic          push;
    logic          ram_we;
    pos_t          start_pos;

    logic          accept;
    logic          out_free;
    logic          out_load;
    logic          is_flush;
    logic          rd_en;
    logic [7:0]    rd_data;
    logic [2:0]    pos_inc;
    pos_t          next_pos;
    logic [7:0]    item_byte;
    kind_t         item_kind;
    logic          item_ovf;
    kind_t         flush_kind;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        slash_next         = slash_reg;
        in_query_next      = in_query_reg;
        saw_eq_next        = saw_eq_reg;
        value_started_next = value_started_reg;
        len_next           = len_reg;
        dropped_next       = dropped_reg;
        plan_next          = '0;
        flen_next          = '0;
        fovf_next          = 1'b0;
        push               = 1'b0;
        ram_we             = 1'b0;

        if (!in_query_reg) begin
            if (s_tdata == CH_SLASH) begin
                // third slash closes the domain
                if (slash_reg == 2'd2) begin
                    plan_next.pre1_v    = 1'b1;
                    plan_next.pre1_kind = K_FEND;
                    slash_next          = 2'd3;
                end else if (slash_reg < 2'd2) begin
                    slash_next = slash_reg + 2'd1;
                end
                len_next     = '0;
                dropped_next = 1'b0;
            end else if (s_tdata == CH_QUERY) begin
                // domain still open gets its field end, then the method goes out
                if (slash_reg != 2'd3) begin
                    plan_next.pre1_v    = 1'b1;
                    plan_next.pre1_kind = K_FEND;
                end
                plan_next.flush1_v    = 1'b1;
                plan_next.flush1_kind = K_METHOD;
                flen_next             = len_reg;
                fovf_next             = dropped_reg;
                in_query_next         = 1'b1;
                len_next              = '0;
                dropped_next          = 1'b0;
            end else begin
                if (slash_reg == 2'd2) begin
                    plan_next.pre1_v    = 1'b1;
                    plan_next.pre1_kind = K_DOMAIN;
                end
                push = 1'b1;
            end
        end else begin
            if (s_tdata == CH_AMP) begin
                // close the pair
                if (value_started_reg) begin
                    plan_next.pre1_v    = 1'b1;
                    plan_next.pre1_kind = K_FEND;
                end else if (!saw_eq_reg && (len_reg != '0)) begin
                    plan_next.flush1_v    = 1'b1;
                    plan_next.flush1_kind = K_KEY;
                    plan_next.flush2_v    = 1'b1;
                    flen_next             = len_reg;
                    fovf_next             = dropped_reg;
                end
                saw_eq_next        = 1'b0;
                value_started_next = 1'b0;
                len_next           = '0;
                dropped_next       = 1'b0;
            end else if ((s_tdata == CH_EQUALS) && !saw_eq_reg) begin
                saw_eq_next = 1'b1;
            end else if (saw_eq_reg) begin
                // first value byte releases the buffered key
                if (!value_started_reg) begin
                    plan_next.flush1_v    = 1'b1;
                    plan_next.flush1_kind = K_KEY;
                    flen_next             = len_reg;
                    fovf_next             = dropped_reg;
                    len_next              = '0;
                    dropped_next          = 1'b0;
                    value_started_next    = 1'b1;
                end
                plan_next.post1_v = 1'b1;
            end else begin
                push = 1'b1;
            end
        end

        if (push) begin
            if (len_reg < LW'(TOKEN_MAX)) begin
                ram_we   = accept;
                len_next = len_reg + LW'(1);
            end else begin
                dropped_next = 1'b1;
            end
        end

        if (s_tlast) begin
            // line end closes whatever field is open, using post-update state
            if (!in_query_next) begin
                if (slash_next != 2'd3) begin
                    plan_next.pre2_v = 1'b1;
                end
                plan_next.flush1_v    = 1'b1;
                plan_next.flush1_kind = K_METHOD;
                flen_next             = len_next;
                fovf_next             = dropped_next;
            end else if (value_started_next) begin
                plan_next.post2_v = 1'b1;
            end else if (!saw_eq_next && (len_next != '0)) begin
                plan_next.flush1_v    = 1'b1;
                plan_next.flush1_kind = K_KEY;
                plan_next.flush2_v    = 1'b1;
                flen_next             = len_next;
                fovf_next             = dropped_next;
            end
            plan_next.lend_v   = 1'b1;
            slash_next         = 2'd0;
            in_query_next      = 1'b0;
            saw_eq_next        = 1'b0;
            value_started_next = 1'b0;
            len_next           = '0;
            dropped_next       = 1'b0;
        end
    end

    assign start_pos = first_from(3'd0, plan_next);

    // item for the current group
    assign is_flush   = (pos_reg == P_FLUSH1) || (pos_reg == P_FLUSH2);
    assign flush_kind = (pos_reg == P_FLUSH1) ? plan_reg.flush1_kind : K_VALUE;
    assign pos_inc    = pos_reg + 3'd1;
    assign next_pos   = first_from(pos_inc, plan_reg);
    assign rd_en      = (state_reg == S_EMIT) && is_flush && (idx_reg != flen_reg);

    // output register takes a new result this cycle
    assign out_load   = ((state_reg == S_EMIT) && !rd_en && out_free) ||
                        ((state_reg == S_FDATA) && out_free);

    always_comb begin
        item_byte = 8'd0;
        item_kind = K_FEND;
        item_ovf  = 1'b0;
        case (pos_reg)
            P_PRE1: begin
                item_kind = plan_reg.pre1_kind;
                item_byte = (plan_reg.pre1_kind == K_DOMAIN) ? char_reg : 8'd0;
            end
            P_PRE2:   item_kind = K_FEND;
            P_FLUSH1,
            P_FLUSH2: item_ovf  = fovf_reg;
            P_POST1: begin
                item_kind = K_VALUE;
                item_byte = char_reg;
            end
            P_POST2:  item_kind = K_FEND;
            P_LEND:   item_kind = K_LEND;
            default:  item_kind = K_FEND;
        endcase
    end

    uft_ram #(
        .WIDTH(8),
        .DEPTH(TOKEN_MAX)
    ) u_token_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(len_reg[AW-1:0]),
        .wdata(s_tdata),
        .re   (rd_en),
        .raddr(idx_reg[AW-1:0]),
        .rdata(rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            pos_reg           <= P_DONE;
            slash_reg         <= 2'd0;
            in_query_reg      <= 1'b0;
            saw_eq_reg        <= 1'b0;
            value_started_reg <= 1'b0;
            len_reg           <= '0;
            dropped_reg       <= 1'b0;
            idx_reg           <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        slash_reg         <= slash_next;
                        in_query_reg      <= in_query_next;
                        saw_eq_reg        <= saw_eq_next;
                        value_started_reg <= value_started_next;
                        len_reg           <= len_next;
                        dropped_reg       <= dropped_next;
                        plan_reg          <= plan_next;
                        flen_reg          <= flen_next;
                        fovf_reg          <= fovf_next;
                        char_reg          <= s_tdata;
                        idx_reg           <= '0;
                        pos_reg           <= start_pos;
                        state_reg         <= (start_pos == P_DONE) ? S_IDLE : S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (rd_en) begin
                        // buffered byte requested, loaded into the output register from S_FDATA
                        state_reg <= S_FDATA;
                    end else if (out_free) begin
                        m_byte_reg   <= item_byte;
                        m_kind_reg   <= is_flush ? K_FEND : item_kind;
                        m_ovf_reg    <= item_ovf;
                        m_tlast_reg  <= (next_pos == P_DONE);
                        pos_reg      <= next_pos;
                        idx_reg      <= '0;
                        if (next_pos == P_DONE) begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_FDATA: begin
                    if (out_free) begin
                        m_byte_reg   <= rd_data;
                        m_kind_reg   <= flush_kind;
                        m_ovf_reg    <= fovf_reg;
                        m_tlast_reg  <= 1'b0;
                        idx_reg      <= idx_reg + LW'(1);
                        state_reg    <= S_EMIT;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = {m_ovf_reg, m_kind_reg};
    assign m_tlast  = m_tlast_reg;

    // replay index stays within the captured token length
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> (idx_reg <= flen_reg))
        else $error("token replay index past captured length");

    // token length never exceeds the buffer
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(TOKEN_MAX))
        else $error("token length past buffer depth");

    // a line end marker is always the final result of its request
    a_lend_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_kind_reg == K_LEND)) |-> m_tlast_reg)
        else $error("line end item without tlast");

    // replayed byte is loaded only after its ram read
    a_read_first: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_FDATA) && !$past(state_reg == S_FDATA)) |-> $past(rd_en))
        else $error("ram data used without a read");

    // a line end request returns the parse state to reset values
    a_line_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> ((slash_reg == 2'd0) && !in_query_reg && (len_reg == '0)))
        else $error("parse state not cleared at line end");

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for url_field_tokenizer_unit: byte stream in, tagged field check out
module tb_top;
    import uft_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOK_DEPTH  = TOKEN_MAX_DEFAULT;
    localparam int TAIL_WAIT  = 4 * TOK_DEPTH + 40;  // longest replay plus margin
    localparam int MIN_BYTES  = 170;
    localparam int REPORT_MAX = 10;

    // one url byte waiting to be sent
    typedef struct {
        logic [7:0] ch;
        logic       eol;
    } url_byte_t;

    // one tagged result as the block should send it
    typedef struct {
        logic [7:0] data;
        kind_t      kind;
        logic       ovf;
        logic       last;
    } field_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;  // [7:0] char_in
    logic       s_tlast  = 1'b0;   // line_end
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] out_byte
    logic [3:0] m_tuser;           // [2:0] kind, [3] overflow
    logic       m_tlast;           // last_of_run

    url_byte_t pending_bytes[$];
    field_t    expected_fields[$];
    field_t    step_out[$];

    int unsigned mismatches = 0;
    int          send_gap   = 0;
    int          recv_stall = 0;
    bit          send_calm  = 1'b0;
    bit          recv_calm  = 1'b0;

    // parser state kept alongside the block
    logic [1:0] slashes   = 2'd0;
    logic       in_query  = 1'b0;
    logic       saw_eq    = 1'b0;
    logic       value_on  = 1'b0;
    logic [7:0] tok_mem[TOK_DEPTH];
    logic [4:0] tok_len   = 5'd0;
    logic       tok_lost  = 1'b0;

    url_field_tokenizer_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // field predictor
    // ---------------------------------------------------------------
    task automatic emit(input logic [7:0] d, input kind_t k, input logic ovf);
        field_t f;
        f.data = d;
        f.kind = k;
        f.ovf  = ovf;
        f.last = 1'b0;
        step_out.push_back(f);
    endtask

    task automatic clear_token();
        tok_len  = 5'd0;
        tok_lost = 1'b0;
    endtask

    task automatic hold_byte(input logic [7:0] c);
        if (tok_len < TOK_DEPTH) begin
            tok_mem[tok_len[3:0]] = c;
            tok_len++;
        end else begin
            tok_lost = 1'b1;
        end
    endtask

    // replay the held token under one kind, then its field end
    task automatic flush_token(input kind_t k);
        for (int i = 0; i < tok_len; i++) begin
            emit(tok_mem[i], k, tok_lost);
        end
        emit(8'h00, K_FEND, tok_lost);
    endtask

    task automatic close_pair();
        if (value_on) begin
            emit(8'h00, K_FEND, 1'b0);
        end else if (!saw_eq && tok_len > 0) begin
            // pair without '=' goes out as key and again as value
            flush_token(K_KEY);
            flush_token(K_VALUE);
        end
        saw_eq   = 1'b0;
        value_on = 1'b0;
        clear_token();
    endtask

    // work out the fields one accepted byte causes and queue them
    task automatic tokenize_byte(input logic [7:0] c, input logic eol);
        field_t f;
        step_out.delete();
        if (!in_query) begin
            if (c == CH_SLASH) begin
                if (slashes == 2'd2) begin
                    emit(8'h00, K_FEND, 1'b0);
                    slashes = 2'd3;
                end else if (slashes < 2'd2) begin
                    slashes++;
                end
                clear_token();
            end else if (c == CH_QUERY) begin
                if (slashes < 2'd3) emit(8'h00, K_FEND, 1'b0);
                flush_token(K_METHOD);
                in_query = 1'b1;
                clear_token();
            end else begin
                if (slashes == 2'd2) emit(c, K_DOMAIN, 1'b0);
                hold_byte(c);
            end
        end else begin
            if (c == CH_AMP) begin
                close_pair();
            end else if (c == CH_EQUALS && !saw_eq) begin
                saw_eq = 1'b1;
            end else if (saw_eq) begin
                // first value byte releases the held key
                if (!value_on) begin
                    flush_token(K_KEY);
                    clear_token();
                    value_on = 1'b1;
                end
                emit(c, K_VALUE, 1'b0);
            end else begin
                hold_byte(c);
            end
        end
        if (eol) begin
            if (!in_query) begin
                if (slashes < 2'd3) emit(8'h00, K_FEND, 1'b0);
                flush_token(K_METHOD);
            end else begin
                close_pair();
            end
            emit(8'h00, K_LEND, 1'b0);
            slashes  = 2'd0;
            in_query = 1'b0;
            saw_eq   = 1'b0;
            value_on = 1'b0;
            clear_token();
        end
        foreach (step_out[i]) begin
            f = step_out[i];
            f.last = (i == step_out.size() - 1);
            expected_fields.push_back(f);
        end
    endtask

    // ---------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------
    task automatic add_byte(input logic [7:0] c, input logic eol = 1'b0);
        url_byte_t b;
        b.ch  = c;
        b.eol = eol;
        pending_bytes.push_back(b);
    endtask

    // mostly lowercase text, now and then any byte at all
    function automatic logic [7:0] text_byte();
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    // short tokens mostly, some long enough to overflow the token ram
    task automatic add_text(input int short_max);
        int n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(TOK_DEPTH - 1, TOK_DEPTH + 3)
                                        : $urandom_range(0, short_max);
        repeat (n) add_byte(text_byte());
    endtask

    // one line: mostly well formed url text, sometimes delimiter noise
    task automatic add_line();
        int first;
        int pick;
        url_byte_t b;
        first = pending_bytes.size();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 10)) begin
                pick = $urandom_range(0, 5);
                case (pick)
                    0:       add_byte(CH_SLASH);
                    1:       add_byte(CH_QUERY);
                    2:       add_byte(CH_AMP);
                    3:       add_byte(CH_EQUALS);
                    default: add_byte(8'($urandom_range(0, 255)));
                endcase
            end
        end else begin
            add_text(3);
            if ($urandom_range(0, 4) != 0) begin
                add_byte(CH_SLASH);
                add_byte(CH_SLASH);
                add_text(5);
            end
            repeat ($urandom_range(0, 3)) begin
                add_byte(CH_SLASH);
                add_text(5);
            end
            if ($urandom_range(0, 3) != 0) begin
                add_byte(CH_QUERY);
                for (int p = $urandom_range(0, 3); p >= 0; p--) begin
                    add_text(4);
                    if ($urandom_range(0, 4) != 0) begin
                        add_byte(CH_EQUALS);
                        add_text(4);
                    end
                    if (p > 0) add_byte(CH_AMP);
                end
            end
        end
        if (pending_bytes.size() == first) add_byte(text_byte());
        b = pending_bytes.pop_back();
        b.eol = 1'b1;
        pending_bytes.push_back(b);
    endtask

    // random pause length: mostly none or short, a few long
    function automatic int pick_pause(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    // ---------------------------------------------------------------
    // request driver: prediction is made on each accepted request
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : driver
        url_byte_t b;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) tokenize_byte(s_tdata, s_tlast);
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                b = pending_bytes.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= b.ch;
                s_tlast  <= b.eol;
                if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
                send_gap = pick_pause(send_calm);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // result monitor with random backpressure
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        field_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_fields.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result: data %02h kind %0d ovf %0b last %0b",
                                 m_tdata, m_tuser[2:0], m_tuser[3], m_tlast);
                end else begin
                    e = expected_fields.pop_front();
                    if (m_tdata !== e.data || m_tuser[2:0] !== e.kind ||
                        m_tuser[3] !== e.ovf || m_tlast !== e.last) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("result mismatch: got data %02h kind %0d ovf %0b last %0b, %s",
                                     m_tdata, m_tuser[2:0], m_tuser[3], m_tlast,
                                     $sformatf("expected data %02h kind %0d ovf %0b last %0b",
                                               e.data, e.kind, e.ovf, e.last));
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
                recv_stall = pick_pause(recv_calm);
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus and end of run
    // ---------------------------------------------------------------
    initial begin
        // domain ff, empty method after the third slash, empty key, key without
        // '=', empty pair, empty value, '?' and '/' inside a key, '=' in a value
        add_byte(CH_SLASH);
        add_byte(CH_SLASH);
        add_byte(8'hFF);
        add_byte(CH_SLASH);
        add_byte(CH_QUERY);
        add_byte(CH_EQUALS);
        add_byte(8'h00);
        add_byte(CH_AMP);
        add_byte("k");
        add_byte(CH_AMP);
        add_byte(CH_AMP);
        add_byte("e");
        add_byte(CH_EQUALS);
        add_byte(CH_AMP);
        add_byte("a");
        add_byte(CH_QUERY);
        add_byte(CH_SLASH);
        add_byte(CH_EQUALS);
        add_byte(CH_EQUALS);
        add_byte("b", 1'b1);
        // no slash at all: empty domain, method is the text before '?'
        add_byte("a");
        add_byte("b");
        add_byte(CH_QUERY);
        add_byte("x", 1'b1);

        while (pending_bytes.size() < MIN_BYTES) add_line();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_bytes.size() != 0 || s_tvalid || expected_fields.size() != 0)
            @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // hang guard
    initial begin
        #10ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
